// ===== rtl/cell_discharge_capacity_meter_top_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the cell discharge capacity meter
// Clock i_clk, synchronous active-low reset i_rst_n.
// ----------------------------------------------------------------------------
`ifndef CELL_DISCHARGE_CAPACITY_METER_TOP_DEFINES_SVH
`define CELL_DISCHARGE_CAPACITY_METER_TOP_DEFINES_SVH

// same-cycle implication
`define CDCM_CHECK_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define CDCM_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/cdcm_pkg.sv =====
// ----------------------------------------------------------------------------
// cdcm_pkg
// Widths, codes and shared types of the cell discharge capacity meter.
// ----------------------------------------------------------------------------
package cdcm_pkg;

    localparam int unsigned OP_W       = 2;
    localparam int unsigned CH_W       = 3;
    localparam int unsigned CH_EXT_W   = 5;
    localparam int unsigned CODE_W     = 10;
    localparam int unsigned GAIN_W     = 24;
    localparam int unsigned MV_W       = 13;
    localparam int unsigned RES_W      = 16;
    localparam int unsigned IVL_W      = 16;
    localparam int unsigned TIME_W     = 32;
    localparam int unsigned CHARGE_W   = 40;
    localparam int unsigned CFG_W      = 24;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned MV_SHIFT   = 16;
    localparam int unsigned MUL_A_W    = 32;
    localparam int unsigned MUL_B_W    = 13;
    localparam int unsigned PROD_W     = MUL_A_W + MUL_B_W;
    localparam int unsigned MUL_CNT_W  = 4;
    localparam int unsigned DIV_CNT_W  = 6;

    localparam logic [GAIN_W-1:0] GAIN_RST   = 24'd334401;
    localparam logic [MV_W-1:0]   CUTOFF_RST = 13'd2800;
    localparam logic [RES_W-1:0]  RES_RST    = 16'd2700;
    localparam logic [IVL_W-1:0]  IVL_RST    = 16'd1000;

    localparam logic [CFG_IDX_W-1:0] REG_GAIN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CUTOFF = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RES    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IVL    = 2'd3;

    typedef enum logic [OP_W-1:0] {
        OP_SAMPLE = 2'd0,
        OP_RESET  = 2'd1,
        OP_START  = 2'd2,
        OP_STOP   = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_KILL,
        CMD_CLEAR,
        CMD_ACCUM,
        CMD_START,
        CMD_STOP
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind         kind;
        logic [CH_W-1:0]   ch;
        logic              live;
        logic [PROD_W-1:0] inc;
        logic [TIME_W-1:0] elapsed;
        logic [TIME_W-1:0] now;
    } t_cmd;

    typedef struct packed {
        logic                live;
        logic                run;
        logic [TIME_W-1:0]   stamp;
        logic [CHARGE_W-1:0] charge;
        logic [TIME_W-1:0]   time_ms;
    } t_chan_view;

    typedef struct packed {
        logic               start;
        logic [MUL_A_W-1:0] a;
        logic [MUL_B_W-1:0] b;
    } t_mul_req;

    typedef struct packed {
        logic              start;
        logic [PROD_W-1:0] dividend;
        logic [RES_W-1:0]  divisor;
    } t_div_req;

endpackage

// ===== rtl/cdcm_if.sv =====
// ----------------------------------------------------------------------------
// cdcm_in_if / cdcm_out_if
// Valid/ready channels for input words and result words.
// ----------------------------------------------------------------------------
interface cdcm_in_if;
    logic                          valid;
    logic                          ready;
    logic [cdcm_pkg::OP_W-1:0]     operation;
    logic [cdcm_pkg::CH_W-1:0]     channel;
    logic [cdcm_pkg::CODE_W-1:0]   adc_code;
    logic [cdcm_pkg::TIME_W-1:0]   now_ms;

    modport source (output valid, operation, channel, adc_code, now_ms, input ready);
    modport sink   (input valid, operation, channel, adc_code, now_ms, output ready);
endinterface

interface cdcm_out_if;
    logic                          valid;
    logic                          ready;
    logic [cdcm_pkg::CH_W-1:0]     out_channel;
    logic [cdcm_pkg::MV_W-1:0]     voltage_mv;
    logic                          cell_running;
    logic                          load_on;
    logic [cdcm_pkg::CHARGE_W-1:0] charge_mas;
    logic [cdcm_pkg::TIME_W-1:0]   time_ms;

    modport source (output valid, out_channel, voltage_mv, cell_running, load_on,
                    charge_mas, time_ms, input ready);
    modport sink   (input valid, out_channel, voltage_mv, cell_running, load_on,
                    charge_mas, time_ms, output ready);
endinterface

// ===== rtl/cdcm_mul.sv =====
// ----------------------------------------------------------------------------
// cdcm_mul
// Bit-serial shift-add multiplier, one multiplier bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module cdcm_mul (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  cdcm_pkg::t_mul_req              i_req,
    output logic                            o_done,
    output logic [cdcm_pkg::PROD_W-1:0]     o_prod
);

    localparam logic [cdcm_pkg::MUL_CNT_W-1:0] LAST =
        cdcm_pkg::MUL_CNT_W'(cdcm_pkg::MUL_B_W - 1);

    logic                               r_busy;
    logic                               r_done;
    logic [cdcm_pkg::MUL_CNT_W-1:0]     r_cnt;
    logic [cdcm_pkg::MUL_A_W-1:0]       r_a;
    logic [cdcm_pkg::MUL_B_W-1:0]       r_b;
    logic [cdcm_pkg::PROD_W-1:0]        r_acc;
    logic [cdcm_pkg::PROD_W-1:0]        n_acc;

    always_comb begin
        n_acc = {r_acc[cdcm_pkg::PROD_W-2:0], 1'b0};
        if (r_b[cdcm_pkg::MUL_B_W-1]) begin
            n_acc = n_acc + {{cdcm_pkg::MUL_B_W{1'b0}}, r_a};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_a    <= i_req.a;
                r_b    <= i_req.b;
                r_acc  <= '0;
            end else if (r_busy) begin
                r_acc <= n_acc;
                r_b   <= {r_b[cdcm_pkg::MUL_B_W-2:0], 1'b0};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

// ===== rtl/cdcm_div.sv =====
// ----------------------------------------------------------------------------
// cdcm_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cdcm_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  cdcm_pkg::t_div_req              i_req,
    output logic                            o_done,
    output logic [cdcm_pkg::PROD_W-1:0]     o_quot
);

    localparam logic [cdcm_pkg::DIV_CNT_W-1:0] LAST =
        cdcm_pkg::DIV_CNT_W'(cdcm_pkg::PROD_W - 1);

    logic                               r_busy;
    logic                               r_done;
    logic [cdcm_pkg::DIV_CNT_W-1:0]     r_cnt;
    logic [cdcm_pkg::PROD_W-1:0]        r_q;
    logic [cdcm_pkg::RES_W-1:0]         r_rem;
    logic [cdcm_pkg::RES_W-1:0]         r_d;
    logic [cdcm_pkg::RES_W:0]           shifted;
    logic [cdcm_pkg::RES_W:0]           diff;
    logic                               qbit;

    always_comb begin
        shifted = {r_rem, r_q[cdcm_pkg::PROD_W-1]};
        diff    = shifted - {1'b0, r_d};
        qbit    = (shifted >= {1'b0, r_d});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_q    <= i_req.dividend;
                r_d    <= i_req.divisor;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_rem <= qbit ? diff[cdcm_pkg::RES_W-1:0] : shifted[cdcm_pkg::RES_W-1:0];
                r_q   <= {r_q[cdcm_pkg::PROD_W-2:0], qbit};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

// ===== rtl/cdcm_store.sv =====
// ----------------------------------------------------------------------------
// cdcm_store
// Per-channel live flag, charge, time and stamp, plus the run flag.
// ----------------------------------------------------------------------------
module cdcm_store #(
    parameter int unsigned CHANNELS = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  cdcm_pkg::t_cmd                  i_cmd,
    input  logic [cdcm_pkg::CH_W-1:0]       i_rd_ch,
    output cdcm_pkg::t_chan_view            o_view
);

    localparam int unsigned IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [cdcm_pkg::CH_EXT_W-1:0] CH_LIM = cdcm_pkg::CH_EXT_W'(CHANNELS);

    logic                               r_run;
    logic                               r_live   [CHANNELS];
    logic [cdcm_pkg::CHARGE_W-1:0]      r_charge [CHANNELS];
    logic [cdcm_pkg::TIME_W-1:0]        r_time   [CHANNELS];
    logic [cdcm_pkg::TIME_W-1:0]        r_stamp  [CHANNELS];

    logic [cdcm_pkg::CH_EXT_W-1:0]      wr_ext;
    logic [cdcm_pkg::CH_EXT_W-1:0]      rd_ext;
    logic [IDX_W-1:0]                   widx;
    logic [IDX_W-1:0]                   ridx;
    logic                               wr_ok;
    logic                               rd_ok;
    logic [cdcm_pkg::CHARGE_W+5:0]      charge_sum;
    logic [cdcm_pkg::TIME_W:0]          time_sum;
    logic [cdcm_pkg::CHARGE_W-1:0]      charge_sat;
    logic [cdcm_pkg::TIME_W-1:0]        time_sat;

    always_comb begin
        wr_ext = {2'b00, i_cmd.ch};
        rd_ext = {2'b00, i_rd_ch};
        widx   = wr_ext[IDX_W-1:0];
        ridx   = rd_ext[IDX_W-1:0];
        wr_ok  = (wr_ext < CH_LIM);
        rd_ok  = (rd_ext < CH_LIM);

        charge_sum = {6'b0, r_charge[widx]} + {1'b0, i_cmd.inc};
        charge_sat = (|charge_sum[cdcm_pkg::CHARGE_W+5:cdcm_pkg::CHARGE_W]) ?
                     '1 : charge_sum[cdcm_pkg::CHARGE_W-1:0];
        time_sum   = {1'b0, r_time[widx]} + {1'b0, i_cmd.elapsed};
        time_sat   = time_sum[cdcm_pkg::TIME_W] ? '1 : time_sum[cdcm_pkg::TIME_W-1:0];

        o_view.run     = r_run;
        o_view.live    = rd_ok & r_live[ridx];
        o_view.stamp   = r_stamp[ridx];
        o_view.charge  = rd_ok ? r_charge[ridx] : '0;
        o_view.time_ms = rd_ok ? r_time[ridx] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
            for (int i = 0; i < CHANNELS; i++) begin
                r_live[i]   <= 1'b0;
                r_charge[i] <= '0;
                r_time[i]   <= '0;
                r_stamp[i]  <= '0;
            end
        end else begin
            case (i_cmd.kind)
                cdcm_pkg::CMD_KILL: begin
                    if (wr_ok) begin
                        r_live[widx] <= 1'b0;
                    end
                end
                cdcm_pkg::CMD_CLEAR: begin
                    if (wr_ok) begin
                        r_live[widx]   <= i_cmd.live;
                        r_charge[widx] <= '0;
                        r_time[widx]   <= '0;
                    end
                end
                cdcm_pkg::CMD_ACCUM: begin
                    if (wr_ok) begin
                        r_charge[widx] <= charge_sat;
                        r_time[widx]   <= time_sat;
                        r_stamp[widx]  <= i_cmd.now;
                    end
                end
                cdcm_pkg::CMD_START: begin
                    r_run <= 1'b1;
                    for (int i = 0; i < CHANNELS; i++) begin
                        r_stamp[i] <= i_cmd.now;
                    end
                end
                cdcm_pkg::CMD_STOP: begin
                    r_run <= 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

endmodule

// ===== rtl/cell_discharge_capacity_meter_top.sv =====
// ----------------------------------------------------------------------------
// cell_discharge_capacity_meter_top
// Multi-channel discharge tester: scales samples, tracks charge and time.
//
//   port      dir  handshake     word
//   i_item    in   valid/ready   operation, channel, adc_code, now_ms
//   o_result  out  valid/ready   out_channel, voltage_mv, cell_running,
//                                load_on, charge_mas, time_ms
//   i_cfg_*   in   write enable  register index, data
//
// One word at a time. Start/stop go straight from idle to the done state.
// Reset channel or a sample that does not accumulate: one serial scale
// multiply. Accumulating sample: two serial multiplies and the divider.
// Synchronous reset loads register defaults and clears all channel state.
// A result waits in the output register; the next word is processed and
// holds in the done state until that register frees.
// ----------------------------------------------------------------------------
`include "cell_discharge_capacity_meter_top_defines.svh"

module cell_discharge_capacity_meter_top #(
    parameter int unsigned CHANNELS = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    cdcm_in_if.sink                             i_item,
    cdcm_out_if.source                          o_result,
    input  logic                                i_cfg_we,
    input  logic [cdcm_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [cdcm_pkg::CFG_W-1:0]          i_cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCALE,
        S_DECIDE,
        S_PROD,
        S_DIV,
        S_DONE
    } t_state;

    localparam logic [cdcm_pkg::CH_EXT_W-1:0] CH_LIM = cdcm_pkg::CH_EXT_W'(CHANNELS);

    logic [cdcm_pkg::GAIN_W-1:0]    r_gain;
    logic [cdcm_pkg::MV_W-1:0]      r_cut;
    logic [cdcm_pkg::RES_W-1:0]     r_res;
    logic [cdcm_pkg::IVL_W-1:0]     r_ivl;

    t_state                         r_state,    n_state;
    cdcm_pkg::t_op                  r_op,       n_op;
    logic [cdcm_pkg::CH_W-1:0]      r_ch,       n_ch;
    logic [cdcm_pkg::TIME_W-1:0]    r_now,      n_now;
    logic [cdcm_pkg::MV_W-1:0]      r_mv,       n_mv;
    logic [cdcm_pkg::TIME_W-1:0]    r_elapsed,  n_elapsed;

    logic                           r_out_valid,   n_out_valid;
    logic [cdcm_pkg::CH_W-1:0]      r_out_ch,      n_out_ch;
    logic [cdcm_pkg::MV_W-1:0]      r_out_mv,      n_out_mv;
    logic                           r_out_running, n_out_running;
    logic                           r_out_load_on, n_out_load_on;
    logic [cdcm_pkg::CHARGE_W-1:0]  r_out_charge,  n_out_charge;
    logic [cdcm_pkg::TIME_W-1:0]    r_out_time,    n_out_time;

    cdcm_pkg::t_mul_req             mul_req;
    logic                           mul_done;
    logic [cdcm_pkg::PROD_W-1:0]    mul_prod;
    cdcm_pkg::t_div_req             div_req;
    logic                           div_done;
    logic [cdcm_pkg::PROD_W-1:0]    div_quot;
    cdcm_pkg::t_cmd                 cmd;
    cdcm_pkg::t_chan_view           view;

    logic                           accept;
    logic                           ch_ok;
    logic [cdcm_pkg::PROD_W-cdcm_pkg::MV_SHIFT-1:0] mv_raw;
    logic [cdcm_pkg::MV_W-1:0]      mv_sat;
    logic [cdcm_pkg::TIME_W-1:0]    elapsed;
    logic [cdcm_pkg::RES_W-1:0]     res_eff;

    cdcm_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    cdcm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    cdcm_store #(
        .CHANNELS (CHANNELS)
    ) u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_rd_ch (r_ch),
        .o_view  (view)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= cdcm_pkg::GAIN_RST;
            r_cut  <= cdcm_pkg::CUTOFF_RST;
            r_res  <= cdcm_pkg::RES_RST;
            r_ivl  <= cdcm_pkg::IVL_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                cdcm_pkg::REG_GAIN:   r_gain <= i_cfg_data[cdcm_pkg::GAIN_W-1:0];
                cdcm_pkg::REG_CUTOFF: r_cut  <= i_cfg_data[cdcm_pkg::MV_W-1:0];
                cdcm_pkg::REG_RES:    r_res  <= i_cfg_data[cdcm_pkg::RES_W-1:0];
                cdcm_pkg::REG_IVL:    r_ivl  <= i_cfg_data[cdcm_pkg::IVL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        accept  = i_item.valid && (r_state == S_IDLE);
        ch_ok   = ({2'b00, r_ch} < CH_LIM);
        mv_raw  = mul_prod[cdcm_pkg::PROD_W-1:cdcm_pkg::MV_SHIFT];
        mv_sat  = (|mv_raw[cdcm_pkg::PROD_W-cdcm_pkg::MV_SHIFT-1:cdcm_pkg::MV_W]) ?
                  '1 : mv_raw[cdcm_pkg::MV_W-1:0];
        elapsed = r_now - view.stamp;
        res_eff = (r_res == '0) ? cdcm_pkg::RES_W'(1) : r_res;

        n_state   = r_state;
        n_op      = r_op;
        n_ch      = r_ch;
        n_now     = r_now;
        n_mv      = r_mv;
        n_elapsed = r_elapsed;

        n_out_valid   = r_out_valid && !o_result.ready;
        n_out_ch      = r_out_ch;
        n_out_mv      = r_out_mv;
        n_out_running = r_out_running;
        n_out_load_on = r_out_load_on;
        n_out_charge  = r_out_charge;
        n_out_time    = r_out_time;

        mul_req.start = 1'b0;
        mul_req.a     = {{(cdcm_pkg::MUL_A_W-cdcm_pkg::GAIN_W){1'b0}}, r_gain};
        mul_req.b     = {{(cdcm_pkg::MUL_B_W-cdcm_pkg::CODE_W){1'b0}}, i_item.adc_code};

        div_req.start    = 1'b0;
        div_req.dividend = mul_prod;
        div_req.divisor  = res_eff;

        cmd.kind    = cdcm_pkg::CMD_NONE;
        cmd.ch      = r_ch;
        cmd.live    = 1'b0;
        cmd.inc     = div_quot;
        cmd.elapsed = r_elapsed;
        cmd.now     = r_now;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_op  = cdcm_pkg::t_op'(i_item.operation);
                    n_ch  = i_item.channel;
                    n_now = i_item.now_ms;
                    n_mv  = '0;
                    if (n_op == cdcm_pkg::OP_START) begin
                        cmd.kind = cdcm_pkg::CMD_START;
                        cmd.now  = i_item.now_ms;
                        n_state  = S_DONE;
                    end else if (n_op == cdcm_pkg::OP_STOP) begin
                        cmd.kind = cdcm_pkg::CMD_STOP;
                        n_state  = S_DONE;
                    end else begin
                        mul_req.start = 1'b1;
                        n_state       = S_SCALE;
                    end
                end
            end
            S_SCALE: begin
                if (mul_done) begin
                    n_mv    = mv_sat;
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_state = S_DONE;
                if (ch_ok) begin
                    if (r_op == cdcm_pkg::OP_RESET) begin
                        cmd.kind = cdcm_pkg::CMD_CLEAR;
                        cmd.live = (r_mv > r_cut);
                    end else if (view.live && (r_mv <= r_cut)) begin
                        cmd.kind = cdcm_pkg::CMD_KILL;
                    end else if (view.live && view.run &&
                                 (elapsed >= cdcm_pkg::TIME_W'(r_ivl))) begin
                        mul_req.start = 1'b1;
                        mul_req.a     = elapsed;
                        mul_req.b     = r_mv;
                        n_elapsed     = elapsed;
                        n_state       = S_PROD;
                    end
                end
            end
            S_PROD: begin
                if (mul_done) begin
                    div_req.start = 1'b1;
                    n_state       = S_DIV;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    cmd.kind = cdcm_pkg::CMD_ACCUM;
                    n_state  = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || o_result.ready) begin
                    n_out_valid   = 1'b1;
                    n_out_ch      = r_ch;
                    n_out_mv      = r_mv;
                    n_out_running = view.live;
                    n_out_load_on = view.live && view.run;
                    n_out_charge  = view.charge;
                    n_out_time    = view.time_ms;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_op          <= n_op;
        r_ch          <= n_ch;
        r_now         <= n_now;
        r_mv          <= n_mv;
        r_elapsed     <= n_elapsed;
        r_out_ch      <= n_out_ch;
        r_out_mv      <= n_out_mv;
        r_out_running <= n_out_running;
        r_out_load_on <= n_out_load_on;
        r_out_charge  <= n_out_charge;
        r_out_time    <= n_out_time;
    end

    assign i_item.ready          = (r_state == S_IDLE);
    assign o_result.valid        = r_out_valid;
    assign o_result.out_channel  = r_out_ch;
    assign o_result.voltage_mv   = r_out_mv;
    assign o_result.cell_running = r_out_running;
    assign o_result.load_on      = r_out_load_on;
    assign o_result.charge_mas   = r_out_charge;
    assign o_result.time_ms      = r_out_time;

    `CDCM_CHECK_NOW(a_mul_done_state, mul_done, (r_state == S_SCALE) || (r_state == S_PROD), "multiplier finished outside a multiply state")
    `CDCM_CHECK_NOW(a_div_done_state, div_done, r_state == S_DIV, "divider finished outside the divide state")
    `CDCM_CHECK_NOW(a_load_needs_cell, r_out_valid && r_out_load_on, r_out_running, "load on for a cell that is not running")
    `CDCM_CHECK_NEXT(a_done_loads, (r_state == S_DONE) && (!r_out_valid || o_result.ready), r_out_valid && (r_state == S_IDLE), "finished word not loaded into output register")

endmodule
